// ===== hw/rtl/bbsf_pkg.sv =====
// Shared constants and codes for the bounded byte stream FIFO.
// No dependencies; imported by bbsf_ram, bounded_byte_stream_fifo and the testbench files.
package bbsf_pkg;

    // Item kinds carried on s_tuser
    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_PEEK  = 3'd2;
    localparam logic [2:0] KIND_POP   = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;

    // Field widths
    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int OFFSET_W = 10;
    localparam int FILL_W   = 11;
    localparam int TOTAL_W  = 32;

    // Stream data widths (padded to whole bytes)
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_PAD_W  = OUT_DATA_W - (BYTE_W + 1 + 2 * FILL_W + 2 * TOTAL_W + 2);

    // Reset value of the capacity register
    localparam logic [FILL_W-1:0] CAP_RESET = 11'd1024;

    // Parameter defaults
    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_MAX_READ    = 64;

endpackage

// ===== hw/rtl/bbsf_ram.sv =====
// Byte store: one write port, one read port, registered read data.
// Depends on bbsf_pkg for the byte width.
module bbsf_ram
    import bbsf_pkg::*;
#(
    parameter int DEPTH = DEF_STORE_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bounded_byte_stream_fifo.sv =====
// Bounded byte stream FIFO top level: command decode, pointers, totals, output register.
// Depends on bbsf_pkg and bbsf_ram.
//
// Byte FIFO driven by command items on the s_ stream (write, read, peek, pop, end)
// with one status result per byte read, or one per other item, on the m_ stream.
// Write, peek, pop and end items are each handled on acceptance, so they can be issued
// back to back; a read of n bytes issues one byte per cycle, while the pending result can
// advance, through the single read port of the byte store, and the input is held off until
// its last byte is issued. A result passes through the store read register, then the output
// register once it is free. Capacity may only be changed while the FIFO is idle; values
// above STORE_DEPTH act as STORE_DEPTH. The store needs no clearing pass after reset.
module bounded_byte_stream_fifo
    import bbsf_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int MAX_READ    = DEF_MAX_READ
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [FILL_W-1:0]     cfg_wr_data,   // capacity
    // command stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,       // data_byte, count, offset, zero pad
    input  logic [KIND_W-1:0]     s_tuser,       // kind
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,       // out_byte, accepted, buffered, space_left,
                                                 // written_total, read_total, ended,
                                                 // at_eof, zero pad
    output logic [0:0]            m_tuser,       // byte_valid
    output logic                  m_tlast
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SW = ((AW > FILL_W) ? AW : FILL_W) + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(STORE_DEPTH);
    localparam logic [FILL_W-1:0] CAP_DEPTH =
        FILL_W'((STORE_DEPTH > 2047) ? 2047 : STORE_DEPTH);
    localparam logic [COUNT_W-1:0] MAX_RD = COUNT_W'(MAX_READ);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    typedef struct packed {
        logic bv;
        logic last;
        logic acc;
    } pend_t;

    // state
    logic                  state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [TOTAL_W-1:0]    written_reg, written_next;
    logic [TOTAL_W-1:0]    read_reg, read_next;
    logic                  done_reg, done_next;
    logic [FILL_W-1:0]     cap_reg;
    logic [COUNT_W-1:0]    rem_reg, rem_next;
    logic                  pend_valid_reg, pend_valid_next;
    pend_t                 pend_reg, pend_next;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  m_bv_reg;
    logic                  m_last_reg;

    // store ports
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // decode
    logic [BYTE_W-1:0]   in_data;
    logic [COUNT_W-1:0]  in_count;
    logic [OFFSET_W-1:0] in_offset;
    logic                in_acc;
    logic                adv;
    logic                issue_ok;
    logic [FILL_W-1:0]   eff_cap;
    logic [FILL_W-1:0]   pop_n;
    logic [FILL_W-1:0]   rd_n_fill;
    logic [COUNT_W-1:0]  rd_n;
    logic [FILL_W-1:0]   space;
    logic [BYTE_W-1:0]   res_byte;

    // wrap-around add on the store index; sum stays below twice the depth
    function automatic logic [AW-1:0] idx_add(input logic [AW-1:0] h,
                                              input logic [FILL_W-1:0] n);
        logic [SW-1:0] sum;
        sum = SW'(h) + SW'(n);
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    assign in_data   = s_tdata[BYTE_W-1:0];
    assign in_count  = s_tdata[BYTE_W +: COUNT_W];
    assign in_offset = s_tdata[BYTE_W + COUNT_W +: OFFSET_W];

    assign eff_cap   = (cap_reg < CAP_DEPTH) ? cap_reg : CAP_DEPTH;
    assign pop_n     = (FILL_W'(in_count) < fill_reg) ? FILL_W'(in_count) : fill_reg;
    assign rd_n_fill = pop_n;
    assign rd_n      = (rd_n_fill > FILL_W'(MAX_RD)) ? MAX_RD : rd_n_fill[COUNT_W-1:0];

    // pending result moves to the output register when it is free
    assign adv      = pend_valid_reg && (!m_valid_reg || m_tready);
    assign issue_ok = !pend_valid_reg || adv;
    assign s_tready = (state_reg == ST_IDLE) && issue_ok;
    assign in_acc   = s_tvalid && s_tready;

    // command decode and pointer / count updates
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        written_next    = written_reg;
        read_next       = read_reg;
        done_next       = done_reg;
        rem_next        = rem_reg;
        pend_next       = pend_reg;
        pend_valid_next = adv ? 1'b0 : pend_valid_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_add(head_reg, fill_reg);
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        if (in_acc) begin
            pend_valid_next = 1'b1;
            pend_next       = '{bv: 1'b0, last: 1'b1, acc: 1'b0};
            unique case (s_tuser)
                KIND_WRITE: begin
                    if (fill_reg < eff_cap) begin
                        wr_en         = 1'b1;
                        fill_next     = fill_reg + 1'b1;
                        written_next  = written_reg + 1'b1;
                        pend_next.acc = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (rd_n != '0) begin
                        rd_en          = 1'b1;
                        head_next      = idx_add(head_reg, FILL_W'(1));
                        fill_next      = fill_reg - 1'b1;
                        read_next      = read_reg + 1'b1;
                        pend_next.bv   = 1'b1;
                        pend_next.last = (rd_n == COUNT_W'(1));
                        rem_next       = rd_n - 1'b1;
                        if (rd_n != COUNT_W'(1)) begin
                            state_next = ST_READ;
                        end
                    end
                end
                KIND_PEEK: begin
                    if (FILL_W'(in_offset) < fill_reg) begin
                        rd_en        = 1'b1;
                        rd_addr      = idx_add(head_reg, FILL_W'(in_offset));
                        pend_next.bv = 1'b1;
                    end
                end
                KIND_POP: begin
                    head_next = idx_add(head_reg, pop_n);
                    fill_next = fill_reg - pop_n;
                    read_next = read_reg + TOTAL_W'(pop_n);
                end
                KIND_END: begin
                    done_next = 1'b1;
                end
                default: begin
                    // unknown kind: status only
                end
            endcase
        end else if ((state_reg == ST_READ) && issue_ok) begin
            // one byte of a multi-byte read per cycle, while the pending result can advance
            rd_en           = 1'b1;
            head_next       = idx_add(head_reg, FILL_W'(1));
            fill_next       = fill_reg - 1'b1;
            read_next       = read_reg + 1'b1;
            pend_valid_next = 1'b1;
            pend_next       = '{bv: 1'b1, last: (rem_reg == COUNT_W'(1)), acc: 1'b0};
            rem_next        = rem_reg - 1'b1;
            if (rem_reg == COUNT_W'(1)) begin
                state_next = ST_IDLE;
            end
        end
    end

    // control and status registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            written_reg    <= '0;
            read_reg       <= '0;
            done_reg       <= 1'b0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            cap_reg        <= CAP_RESET;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            written_reg    <= written_next;
            read_reg       <= read_next;
            done_reg       <= done_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

    // status as it stands when the pending result is registered
    assign space    = (fill_reg < eff_cap) ? (eff_cap - fill_reg) : '0;
    assign res_byte = pend_reg.bv ? rd_data : '0;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {{OUT_PAD_W{1'b0}}, done_reg && (fill_reg == '0), done_reg,
                           read_reg, written_reg, space, fill_reg, pend_reg.acc, res_byte};
            m_bv_reg   <= pend_reg.bv;
            m_last_reg <= pend_reg.last;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_bv_reg;
    assign m_tlast    = m_last_reg;

    bbsf_ram #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CAP_DEPTH)
        else $error("fill count exceeds store depth");

    a_totals_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (written_reg - read_reg) == TOTAL_W'(fill_reg))
        else $error("written minus read totals disagree with fill count");

    a_read_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (rem_reg != '0))
        else $error("read burst active with nothing left to issue");

    a_pend_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_valid_reg)
        else $error("pending result lost on its way to the output register");

endmodule

// ===== tb/bbsf_stream_checker.sv =====
// Result checker for bounded_byte_stream_fifo: tracks the FIFO state and predicts
// the status transfers for each command transfer, then compares them field by field.
// Depends on bbsf_pkg.
`timescale 1ns / 1ps

module bbsf_stream_checker
    import bbsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [FILL_W-1:0]     cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,       // data_byte, count, offset, zero pad
    input  logic [KIND_W-1:0]     s_tuser,       // kind
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,       // out_byte, accepted, buffered, space_left,
                                                 // written_total, read_total, ended, at_eof
    input  logic [0:0]            m_tuser,       // byte_valid
    input  logic                  m_tlast,
    output int unsigned           fail_count,
    output int unsigned           pending_count
);

    localparam logic [FILL_W-1:0] DEPTH_LIMIT = DEF_STORE_DEPTH;

    typedef struct {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last;
        logic               accepted;
        logic [FILL_W-1:0]  buffered;
        logic [FILL_W-1:0]  space_left;
        logic [TOTAL_W-1:0] written_total;
        logic [TOTAL_W-1:0] read_total;
        logic               ended;
        logic               at_eof;
    } fifo_status_t;

    // Mirror of the FIFO state
    logic [BYTE_W-1:0]   byte_mem [0:DEF_STORE_DEPTH-1];
    logic [OFFSET_W-1:0] head_idx;
    logic [FILL_W-1:0]   fill;
    logic [TOTAL_W-1:0]  bytes_in;
    logic [TOTAL_W-1:0]  bytes_out;
    logic                end_seen;
    logic [FILL_W-1:0]   capacity;

    fifo_status_t status_due[$];

    // Result fields as packed on the master side
    wire [BYTE_W-1:0]  got_byte     = m_tdata[7:0];
    wire               got_accepted = m_tdata[8];
    wire [FILL_W-1:0]  got_buffered = m_tdata[19:9];
    wire [FILL_W-1:0]  got_space    = m_tdata[30:20];
    wire [TOTAL_W-1:0] got_written  = m_tdata[62:31];
    wire [TOTAL_W-1:0] got_read     = m_tdata[94:63];
    wire               got_ended    = m_tdata[95];
    wire               got_eof      = m_tdata[96];

    function automatic logic [FILL_W-1:0] usable_capacity();
        return (capacity > DEPTH_LIMIT) ? DEPTH_LIMIT : capacity;
    endfunction

    // Queue one status transfer reflecting the state as it stands now
    task automatic push_status(input logic [BYTE_W-1:0] b, input logic valid,
                               input logic last, input logic acc);
        fifo_status_t st;
        logic [FILL_W-1:0] cap_now;
        cap_now          = usable_capacity();
        st.out_byte      = b;
        st.byte_valid    = valid;
        st.last          = last;
        st.accepted      = acc;
        st.buffered      = fill;
        st.space_left    = (fill < cap_now) ? cap_now - fill : '0;
        st.written_total = bytes_in;
        st.read_total    = bytes_out;
        st.ended         = end_seen;
        st.at_eof        = end_seen && (fill == '0);
        status_due.push_back(st);
    endtask

    // Update the mirror for one command and queue what it produces
    task automatic apply_command(input logic [KIND_W-1:0] kind,
                                 input logic [BYTE_W-1:0] data_byte,
                                 input logic [COUNT_W-1:0] count,
                                 input logic [OFFSET_W-1:0] offset);
        logic [OFFSET_W-1:0] pos;
        logic [FILL_W-1:0]   n;
        logic [BYTE_W-1:0]   b;
        logic                took;
        case (kind)
            KIND_WRITE: begin
                took = 1'b0;
                if (fill < usable_capacity()) begin
                    pos           = head_idx + fill[OFFSET_W-1:0];
                    byte_mem[pos] = data_byte;
                    fill          = fill + 1'b1;
                    bytes_in      = bytes_in + 1'b1;
                    took          = 1'b1;
                end
                push_status('0, 1'b0, 1'b1, took);
            end
            KIND_READ: begin
                n = (FILL_W'(count) < fill) ? FILL_W'(count) : fill;
                if (n > FILL_W'(DEF_MAX_READ))
                    n = FILL_W'(DEF_MAX_READ);
                if (n == '0) begin
                    push_status('0, 1'b0, 1'b1, 1'b0);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        b         = byte_mem[head_idx];
                        head_idx  = head_idx + 1'b1;
                        fill      = fill - 1'b1;
                        bytes_out = bytes_out + 1'b1;
                        push_status(b, 1'b1, (i + 1 == n), 1'b0);
                    end
                end
            end
            KIND_PEEK: begin
                if (FILL_W'(offset) < fill) begin
                    pos = head_idx + offset;
                    push_status(byte_mem[pos], 1'b1, 1'b1, 1'b0);
                end else begin
                    push_status('0, 1'b0, 1'b1, 1'b0);
                end
            end
            KIND_POP: begin
                n         = (FILL_W'(count) < fill) ? FILL_W'(count) : fill;
                head_idx  = head_idx + n[OFFSET_W-1:0];
                fill      = fill - n;
                bytes_out = bytes_out + TOTAL_W'(n);
                push_status('0, 1'b0, 1'b1, 1'b0);
            end
            KIND_END: begin
                end_seen = 1'b1;
                push_status('0, 1'b0, 1'b1, 1'b0);
            end
            default: begin
                // reserved kinds leave the state alone
                push_status('0, 1'b0, 1'b1, 1'b0);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Predict on command transfers, compare on result transfers
    always @(posedge aclk) begin
        fifo_status_t want;
        if (!aresetn) begin
            head_idx   = '0;
            fill       = '0;
            bytes_in   = '0;
            bytes_out  = '0;
            end_seen   = 1'b0;
            capacity   = CAP_RESET;
            fail_count = 0;
            status_due.delete();
        end else begin
            if (cfg_wr_en)
                capacity = cfg_wr_data;
            if (s_tvalid && s_tready)
                apply_command(s_tuser, s_tdata[7:0], s_tdata[14:8], s_tdata[24:15]);
            if (m_tvalid && m_tready) begin
                if (status_due.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end else begin
                    want = status_due.pop_front();
                    check_field("out_byte", TOTAL_W'(want.out_byte), TOTAL_W'(got_byte));
                    check_field("byte_valid", TOTAL_W'(want.byte_valid),
                                TOTAL_W'(m_tuser[0]));
                    check_field("last", TOTAL_W'(want.last), TOTAL_W'(m_tlast));
                    check_field("accepted", TOTAL_W'(want.accepted),
                                TOTAL_W'(got_accepted));
                    check_field("buffered", TOTAL_W'(want.buffered),
                                TOTAL_W'(got_buffered));
                    check_field("space_left", TOTAL_W'(want.space_left),
                                TOTAL_W'(got_space));
                    check_field("written_total", want.written_total, got_written);
                    check_field("read_total",    want.read_total,    got_read);
                    check_field("ended", TOTAL_W'(want.ended), TOTAL_W'(got_ended));
                    check_field("at_eof", TOTAL_W'(want.at_eof), TOTAL_W'(got_eof));
                end
            end
        end
        pending_count = status_due.size();
    end

endmodule

// ===== tb/bounded_byte_stream_fifo_tb.sv =====
// Top of the bounded_byte_stream_fifo testbench: clock, reset, command stimulus,
// capacity changes and the verdict. Depends on bbsf_pkg, the block and bbsf_stream_checker.
`timescale 1ns / 1ps

module bounded_byte_stream_fifo_tb;
    import bbsf_pkg::*;

    localparam int          CYCLE_LIMIT     = 600000;
    localparam logic [2:0]  KIND_RSVD_FIRST = 3'd5;
    localparam logic [2:0]  KIND_RSVD_LAST  = 3'd7;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [FILL_W-1:0]     cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic [KIND_W-1:0]     s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned cycle_count   = 0;
    int unsigned tx_gap_pct    = 22;
    int unsigned rx_stall_pct  = 57;

    always #6 aclk = ~aclk;

    bounded_byte_stream_fifo uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    bbsf_stream_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bounded_byte_stream_fifo_tb: FAIL");
            $finish;
        end
    end

    // One command transfer; returns at the falling edge after the handshake
    task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data_byte,
                            input logic [COUNT_W-1:0] count,
                            input logic [OFFSET_W-1:0] offset);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, offset, count, data_byte};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic random_cmd();
        int unsigned         pick;
        logic [KIND_W-1:0]   kind_v;
        logic [BYTE_W-1:0]   data_v;
        logic [COUNT_W-1:0]  count_v;
        logic [OFFSET_W-1:0] offset_v;
        pick     = $urandom_range(99);
        data_v   = BYTE_W'($urandom);
        count_v  = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(127))
                                            : COUNT_W'($urandom_range(8));
        offset_v = ($urandom_range(3) == 0) ? OFFSET_W'($urandom_range(1023))
                                            : OFFSET_W'($urandom_range(15));
        if (pick < 45)
            kind_v = KIND_WRITE;
        else if (pick < 62)
            kind_v = KIND_READ;
        else if (pick < 77)
            kind_v = KIND_PEEK;
        else if (pick < 87)
            kind_v = KIND_POP;
        else if (pick < 92)
            kind_v = KIND_END;
        else
            kind_v = KIND_W'($urandom_range(KIND_RSVD_LAST, KIND_RSVD_FIRST));
        send_cmd(kind_v, data_v, count_v, offset_v);
    endtask

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_capacity(input logic [FILL_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty cases, full, peeks at the edges, clamps, end of input
        set_capacity(11'd4);
        send_cmd(KIND_READ, 8'h00, 7'd5, 10'd0);
        send_cmd(KIND_POP, 8'h00, 7'd3, 10'd0);
        send_cmd(KIND_PEEK, 8'h00, 7'd0, 10'd0);
        send_cmd(KIND_RSVD_FIRST, 8'hFF, 7'd127, 10'd1023);
        send_cmd(KIND_RSVD_LAST, 8'h00, 7'd0, 10'd0);
        send_cmd(KIND_WRITE, 8'h00, 7'd0, 10'd0);
        send_cmd(KIND_WRITE, 8'hFF, 7'd0, 10'd0);
        send_cmd(KIND_WRITE, 8'hA5, 7'd0, 10'd0);
        send_cmd(KIND_WRITE, 8'h5A, 7'd0, 10'd0);
        send_cmd(KIND_WRITE, 8'h3C, 7'd0, 10'd0);     // full, dropped
        send_cmd(KIND_PEEK, 8'h00, 7'd0, 10'd0);
        send_cmd(KIND_PEEK, 8'h00, 7'd0, 10'd3);
        send_cmd(KIND_PEEK, 8'h00, 7'd0, 10'd4);      // just past contents
        send_cmd(KIND_PEEK, 8'h00, 7'd0, 10'd1023);
        send_cmd(KIND_READ, 8'h00, 7'd0, 10'd0);
        send_cmd(KIND_READ, 8'h00, 7'd2, 10'd0);
        send_cmd(KIND_POP, 8'h00, 7'd127, 10'd0);     // clamped to fill
        send_cmd(KIND_WRITE, 8'h01, 7'd0, 10'd0);
        send_cmd(KIND_WRITE, 8'h02, 7'd0, 10'd0);
        send_cmd(KIND_END, 8'h00, 7'd0, 10'd0);
        send_cmd(KIND_WRITE, 8'h03, 7'd0, 10'd0);     // still taken after end
        send_cmd(KIND_READ, 8'h00, 7'd64, 10'd0);
        send_cmd(KIND_READ, 8'h00, 7'd1, 10'd0);      // empty and ended
        wait_idle();

        // Capacity above store depth
        set_capacity(11'd2047);
        repeat (10) random_cmd();
        wait_idle();

        // Swap idling; capacity lowered under the current fill, then zero
        tx_gap_pct   = 57;
        rx_stall_pct = 22;
        set_capacity(11'd1);
        repeat (10) random_cmd();
        wait_idle();
        set_capacity(11'd0);
        repeat (5) random_cmd();
        wait_idle();

        // No idling; fill past the read limit, then long reads
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        set_capacity(11'd1024);
        repeat (66) send_cmd(KIND_WRITE, BYTE_W'($urandom), 7'd0, 10'd0);
        send_cmd(KIND_PEEK, 8'h00, 7'd0, 10'd65);
        send_cmd(KIND_READ, 8'h00, 7'd127, 10'd0);
        send_cmd(KIND_READ, 8'h00, 7'd100, 10'd0);
        repeat (8) random_cmd();
        wait_idle();

        set_capacity(11'd100);
        repeat (5) random_cmd();
        wait_idle();

        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("bounded_byte_stream_fifo_tb: PASS");
        else
            $display("bounded_byte_stream_fifo_tb: FAIL");
        $finish;
    end

endmodule
